// ----- rtl/mer_pkg.sv -----
// Shared command codes, operand selects and control structs of the ellipse rasterizer.
package mer_pkg;

  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_RX2   = 4'd2;
  localparam logic [3:0] OP_RY2   = 4'd3;
  localparam logic [3:0] OP_INIT1 = 4'd4;
  localparam logic [3:0] OP_DLOAD = 4'd5;
  localparam logic [3:0] OP_DADD4 = 4'd6;
  localparam logic [3:0] OP_DSUB4 = 4'd7;
  localparam logic [3:0] OP_STEP1 = 4'd8;
  localparam logic [3:0] OP_STEP2 = 4'd9;
  localparam logic [3:0] OP_EMIT  = 4'd10;

  localparam logic [2:0] SEL_RADX = 3'd0;
  localparam logic [2:0] SEL_OFFY = 3'd1;
  localparam logic [2:0] SEL_RX2  = 3'd2;
  localparam logic [2:0] SEL_RY2  = 3'd3;
  localparam logic [2:0] SEL_PROD = 3'd4;
  localparam logic [2:0] SEL_TX   = 3'd5;
  localparam logic [2:0] SEL_TY   = 3'd6;

  typedef struct packed {
    logic       mul_en;
    logic [2:0] mul_a;
    logic [2:0] mul_b;
    logic [3:0] op;
  } mer_cmd_t;

  typedef struct packed {
    logic reg1_go;
    logic y_zero;
  } mer_status_t;

endpackage

// ----- rtl/mer_cmd_if.sv -----
// Input channel: start and step items with radii and centre.
interface mer_cmd_if #(
  parameter int RADIUS_BITS = 12,
  parameter int COORD_BITS  = 14
);
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [RADIUS_BITS-1:0]       radius_x;
  logic [RADIUS_BITS-1:0]       radius_y;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;

  modport source (output valid, func, radius_x, radius_y, center_x, center_y, input ready);
  modport sink (input valid, func, radius_x, radius_y, center_x, center_y, output ready);
endinterface

// ----- rtl/mer_pixel_if.sv -----
// Output channel: the four symmetric outline points of one pixel.
interface mer_pixel_if #(
  parameter int COORD_BITS = 14
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] right_x;
  logic signed [COORD_BITS:0] left_x;
  logic signed [COORD_BITS:0] top_y;
  logic signed [COORD_BITS:0] bottom_y;
  logic                       last;

  modport source (output valid, right_x, left_x, top_y, bottom_y, last, input ready);
  modport sink (input valid, right_x, left_x, top_y, bottom_y, last, output ready);
endinterface

// ----- rtl/mer_datapath.sv -----
// Datapath: radii squares, offsets, scaled decision, shared multiplier and output register.
module mer_datapath #(
  parameter int RADIUS_BITS = 12,
  parameter int COORD_BITS  = 14
) (
  input  logic                         clk,
  input  mer_pkg::mer_cmd_t            cmd,
  input  logic [RADIUS_BITS-1:0]       radius_x,
  input  logic [RADIUS_BITS-1:0]       radius_y,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  output mer_pkg::mer_status_t         status,
  output logic signed [COORD_BITS:0]   right_x,
  output logic signed [COORD_BITS:0]   left_x,
  output logic signed [COORD_BITS:0]   top_y,
  output logic signed [COORD_BITS:0]   bottom_y,
  output logic                         last
);

  localparam int R  = RADIUS_BITS;
  localparam int C  = COORD_BITS;
  localparam int MW = 2 * R + 2;   // multiplier operand width
  localparam int DW = 4 * R + 8;   // decision width, scaled by 4
  localparam int SW = ((R > C) ? R : C) + 2;

  logic [R-1:0]      rad_x;
  logic [R-1:0]      offset_x;
  logic [R-1:0]      offset_y;
  logic [2*R-1:0]    rx2;
  logic [2*R-1:0]    ry2;
  logic [3*R-1:0]    sx;        // ry^2 * x
  logic [3*R-1:0]    sy;        // rx^2 * y
  logic [DW-1:0]     dec;
  logic [2*MW-1:0]   prod;
  logic [C-1:0]      centre_x;
  logic [C-1:0]      centre_y;

  logic [MW-1:0]     op_a;
  logic [MW-1:0]     op_b;
  logic [2*MW-1:0]   mul_out;
  logic [R:0]        tx;
  logic [R-1:0]      ty;
  logic [3*R-1:0]    sx_inc;
  logic [3*R-1:0]    sy_dec;
  logic [DW-1:0]     sx_w;
  logic [DW-1:0]     sy_w;
  logic [DW-1:0]     rx2_w;
  logic [DW-1:0]     ry2_w;
  logic [DW-1:0]     prod_w;
  logic [DW-1:0]     d_s1_neg;
  logic [DW-1:0]     d_s1_pos;
  logic [DW-1:0]     d_s2_pos;
  logic [DW-1:0]     d_s2_neg;
  logic              d_neg;
  logic              d_pos;
  logic [SW-1:0]     cx_w;
  logic [SW-1:0]     cy_w;
  logic [SW-1:0]     ox_w;
  logic [SW-1:0]     oy_w;
  logic [SW-1:0]     sum_rx;
  logic [SW-1:0]     sum_lx;
  logic [SW-1:0]     sum_ty;
  logic [SW-1:0]     sum_by;

  assign tx = {offset_x, 1'b1};
  assign ty = offset_y - 1'b1;

  always_comb begin
    unique case (cmd.mul_a)
      mer_pkg::SEL_RADX: op_a = {{(MW-R){1'b0}}, rad_x};
      mer_pkg::SEL_OFFY: op_a = {{(MW-R){1'b0}}, offset_y};
      mer_pkg::SEL_RX2:  op_a = {2'b00, rx2};
      mer_pkg::SEL_RY2:  op_a = {2'b00, ry2};
      mer_pkg::SEL_PROD: op_a = prod[MW-1:0];
      mer_pkg::SEL_TX:   op_a = {{(MW-R-1){1'b0}}, tx};
      mer_pkg::SEL_TY:   op_a = {{(MW-R){1'b0}}, ty};
      default:           op_a = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.mul_b)
      mer_pkg::SEL_RADX: op_b = {{(MW-R){1'b0}}, rad_x};
      mer_pkg::SEL_OFFY: op_b = {{(MW-R){1'b0}}, offset_y};
      mer_pkg::SEL_RX2:  op_b = {2'b00, rx2};
      mer_pkg::SEL_RY2:  op_b = {2'b00, ry2};
      mer_pkg::SEL_PROD: op_b = prod[MW-1:0];
      mer_pkg::SEL_TX:   op_b = {{(MW-R-1){1'b0}}, tx};
      mer_pkg::SEL_TY:   op_b = {{(MW-R){1'b0}}, ty};
      default:           op_b = '0;
    endcase
  end

  assign mul_out = {{MW{1'b0}}, op_a} * {{MW{1'b0}}, op_b};

  // incremental products for the next pixel
  assign sx_inc = sx + {{R{1'b0}}, ry2};
  assign sy_dec = sy - {{R{1'b0}}, rx2};
  assign sx_w   = {{(DW-3*R){1'b0}}, sx_inc};
  assign sy_w   = {{(DW-3*R){1'b0}}, sy_dec};
  assign rx2_w  = {{(DW-2*R){1'b0}}, rx2};
  assign ry2_w  = {{(DW-2*R){1'b0}}, ry2};
  assign prod_w = {{(DW-2*MW){1'b0}}, prod};

  assign d_s1_neg = dec + (sx_w << 3) + (ry2_w << 2);
  assign d_s1_pos = d_s1_neg - (sy_w << 3);
  assign d_s2_pos = dec + (rx2_w << 2) - (sy_w << 3);
  assign d_s2_neg = d_s2_pos + (sx_w << 3);

  assign d_neg = dec[DW-1];
  assign d_pos = !dec[DW-1] && (dec != '0);

  assign status.reg1_go = (sx < sy);
  assign status.y_zero  = (offset_y == '0);

  // outline points wrap to the output width
  assign cx_w   = {{(SW-C){centre_x[C-1]}}, centre_x};
  assign cy_w   = {{(SW-C){centre_y[C-1]}}, centre_y};
  assign ox_w   = {{(SW-R){1'b0}}, offset_x};
  assign oy_w   = {{(SW-R){1'b0}}, offset_y};
  assign sum_rx = cx_w + ox_w;
  assign sum_lx = cx_w - ox_w;
  assign sum_ty = cy_w + oy_w;
  assign sum_by = cy_w - oy_w;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_out;
    end
    unique case (cmd.op)
      mer_pkg::OP_NONE: begin
      end
      mer_pkg::OP_LOAD: begin
        rad_x    <= radius_x;
        offset_x <= '0;
        offset_y <= radius_y;
        sx       <= '0;
        centre_x <= center_x;
        centre_y <= center_y;
      end
      mer_pkg::OP_RX2: begin
        rx2 <= prod[2*R-1:0];
      end
      mer_pkg::OP_RY2: begin
        ry2 <= prod[2*R-1:0];
      end
      mer_pkg::OP_INIT1: begin
        sy  <= prod[3*R-1:0];
        dec <= (ry2_w << 2) + rx2_w - (prod_w << 2);
      end
      mer_pkg::OP_DLOAD: begin
        dec <= prod_w;
      end
      mer_pkg::OP_DADD4: begin
        dec <= dec + (prod_w << 2);
      end
      mer_pkg::OP_DSUB4: begin
        dec <= dec - (prod_w << 2);
      end
      mer_pkg::OP_STEP1: begin
        offset_x <= offset_x + 1'b1;
        sx       <= sx_inc;
        if (d_neg) begin
          dec <= d_s1_neg;
        end else begin
          offset_y <= offset_y - 1'b1;
          sy       <= sy_dec;
          dec      <= d_s1_pos;
        end
      end
      mer_pkg::OP_STEP2: begin
        offset_y <= offset_y - 1'b1;
        sy       <= sy_dec;
        if (d_pos) begin
          dec <= d_s2_pos;
        end else begin
          offset_x <= offset_x + 1'b1;
          sx       <= sx_inc;
          dec      <= d_s2_neg;
        end
      end
      mer_pkg::OP_EMIT: begin
        right_x  <= sum_rx[C:0];
        left_x   <= sum_lx[C:0];
        top_y    <= sum_ty[C:0];
        bottom_y <= sum_by[C:0];
        last     <= status.y_zero;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/mer_ctrl.sv -----
// Controller: region phase, command sequencing and output valid.
module mer_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_func,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mer_pkg::mer_status_t status,
  output mer_pkg::mer_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ST1  = 4'd1;
  localparam logic [3:0] S_ST2  = 4'd2;
  localparam logic [3:0] S_ST3  = 4'd3;
  localparam logic [3:0] S_ST4  = 4'd4;
  localparam logic [3:0] S_E1   = 4'd5;
  localparam logic [3:0] S_E2   = 4'd6;
  localparam logic [3:0] S_E3   = 4'd7;
  localparam logic [3:0] S_E4   = 4'd8;
  localparam logic [3:0] S_E5   = 4'd9;
  localparam logic [3:0] S_E6   = 4'd10;
  localparam logic [3:0] S_S2   = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_REG1 = 2'd1;
  localparam logic [1:0] PH_REG2 = 2'd2;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] phase;
  logic [1:0] phase_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd.mul_en = 1'b0;
    cmd.mul_a  = mer_pkg::SEL_RADX;
    cmd.mul_b  = mer_pkg::SEL_RADX;
    cmd.op     = mer_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_func) begin
            cmd.op     = mer_pkg::OP_LOAD;
            state_next = S_ST1;
          end else if (phase == PH_REG1) begin
            if (status.reg1_go) begin
              cmd.op     = mer_pkg::OP_STEP1;
              state_next = S_EMIT;
            end else begin
              state_next = S_E1;
            end
          end else if (phase == PH_REG2) begin
            if (status.y_zero) begin
              phase_next = PH_IDLE;
            end else begin
              cmd.op     = mer_pkg::OP_STEP2;
              state_next = S_EMIT;
            end
          end
        end
      end
      S_ST1: begin
        cmd.mul_en = 1'b1;
        state_next = S_ST2;
      end
      S_ST2: begin
        cmd.op     = mer_pkg::OP_RX2;
        cmd.mul_en = 1'b1;
        cmd.mul_a  = mer_pkg::SEL_OFFY;
        cmd.mul_b  = mer_pkg::SEL_OFFY;
        state_next = S_ST3;
      end
      S_ST3: begin
        cmd.op     = mer_pkg::OP_RY2;
        cmd.mul_en = 1'b1;
        cmd.mul_a  = mer_pkg::SEL_RX2;
        cmd.mul_b  = mer_pkg::SEL_OFFY;
        state_next = S_ST4;
      end
      S_ST4: begin
        cmd.op     = mer_pkg::OP_INIT1;
        phase_next = PH_REG1;
        state_next = S_IDLE;
      end
      // region-2 start value: ry2*tx^2 + 4*rx2*ty^2 - 4*rx2*ry2
      S_E1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = mer_pkg::SEL_TX;
        cmd.mul_b  = mer_pkg::SEL_TX;
        state_next = S_E2;
      end
      S_E2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = mer_pkg::SEL_PROD;
        cmd.mul_b  = mer_pkg::SEL_RY2;
        state_next = S_E3;
      end
      S_E3: begin
        cmd.op     = mer_pkg::OP_DLOAD;
        cmd.mul_en = 1'b1;
        cmd.mul_a  = mer_pkg::SEL_TY;
        cmd.mul_b  = mer_pkg::SEL_TY;
        state_next = S_E4;
      end
      S_E4: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = mer_pkg::SEL_PROD;
        cmd.mul_b  = mer_pkg::SEL_RX2;
        state_next = S_E5;
      end
      S_E5: begin
        cmd.op     = mer_pkg::OP_DADD4;
        cmd.mul_en = 1'b1;
        cmd.mul_a  = mer_pkg::SEL_RX2;
        cmd.mul_b  = mer_pkg::SEL_RY2;
        state_next = S_E6;
      end
      S_E6: begin
        cmd.op     = mer_pkg::OP_DSUB4;
        phase_next = PH_REG2;
        state_next = S_S2;
      end
      S_S2: begin
        if (status.y_zero) begin
          phase_next = PH_IDLE;
          state_next = S_IDLE;
        end else begin
          cmd.op     = mer_pkg::OP_STEP2;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.op     = mer_pkg::OP_EMIT;
          state_next = S_IDLE;
          if (status.y_zero) begin
            phase_next = PH_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (cmd.op == mer_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // a new point never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mer_pkg::OP_EMIT) |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && !in_func) |=> (state == S_ST1))
    else $error("start item did not begin setup");

  a_reg2_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_E6) |=> (phase == PH_REG2))
    else $error("region 2 not entered");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mer_pkg::OP_EMIT && status.y_zero) |=> (phase == PH_IDLE && out_valid))
    else $error("last point did not end the outline");
`endif

endmodule

// ----- rtl/midpoint_ellipse_rasterizer_unit.sv -----
// Top level of the midpoint ellipse outline rasterizer.
//
// cmd channel (sink): func 0 starts an ellipse from radius_x, radius_y and the
// centre and gives no result; func 1 steps one pixel along the outline.
// pixel channel (source): right_x, left_x, top_y, bottom_y of the four
// symmetric points; last is high on the point where y reaches 0.
// Sequencing: a start item runs through setup states S_ST1 to S_ST4, which
// use the shared multiplier, before the next item is taken. A step inside a
// region moves to S_EMIT, which writes its point into the output register
// once that register is free; the next item is taken back in S_IDLE. The
// step that crosses into region 2 first runs states S_E1 to S_E6, the six
// multiply/accumulate steps of the region-2 start value, and then S_S2. A
// step with no outline under way, or after the last point, gives no item.
// Reset clears the controller and drops any pending point.
// While the receiver stalls, the finished point is held in the output
// register; one further step item may be taken and is held at its point
// until the register frees.
module midpoint_ellipse_rasterizer_unit #(
  parameter int RADIUS_BITS = 12,
  parameter int COORD_BITS  = 14
) (
  input logic         clk,
  input logic         rst,
  mer_cmd_if.sink     cmd,
  mer_pixel_if.source pixel
);

  mer_pkg::mer_cmd_t    dp_cmd;
  mer_pkg::mer_status_t dp_status;
  logic                 in_ready;
  logic                 out_valid;

  assign cmd.ready   = in_ready;
  assign pixel.valid = out_valid;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_func   (cmd.func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (pixel.ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  mer_datapath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .cmd      (dp_cmd),
    .radius_x (cmd.radius_x),
    .radius_y (cmd.radius_y),
    .center_x (cmd.center_x),
    .center_y (cmd.center_y),
    .status   (dp_status),
    .right_x  (pixel.right_x),
    .left_x   (pixel.left_x),
    .top_y    (pixel.top_y),
    .bottom_y (pixel.bottom_y),
    .last     (pixel.last)
  );

endmodule
